// File: hdl/clpm_pkg.sv
// ----------------------------------------------------------------------------
// clpm_pkg
// shared constants, field positions and command bundle of the complex
// laurent polynomial multiplier
// ----------------------------------------------------------------------------
`default_nettype none

package clpm_pkg;

	// fixed field widths
	localparam int PROD_W     = 42;
	localparam int EXP_W      = 13;
	localparam int START_W    = 11;
	localparam int OUT_DATA_W = ((2 * PROD_W + EXP_W + 7) / 8) * 8;
	localparam int OUT_PAD_W  = OUT_DATA_W - (2 * PROD_W + EXP_W);

	// input tuser bit positions
	localparam int TUSER_REQ_BIT   = 0;
	localparam int TUSER_EMPTY_BIT = 1;

	// request types
	localparam logic REQ_FIRST  = 1'b0;
	localparam logic REQ_SECOND = 1'b1;

	// controller to datapath commands
	typedef struct packed {
		logic wr_a;
		logic wr_b;
		logic ld_start_a;
		logic ld_start_b;
		logic acc_clr;
		logic issue;
		logic load_out;
		logic out_empty;
		logic out_last;
	} cmd_t;

endpackage

`default_nettype wire

// File: hdl/clpm_ram.sv
// ----------------------------------------------------------------------------
// clpm_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module clpm_ram #(
	parameter int WIDTH = 36,
	parameter int DEPTH = 32,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// File: hdl/clpm_dp.sv
// ----------------------------------------------------------------------------
// clpm_dp
// datapath: coefficient stores, complex multiply-accumulate pipeline,
// exponent adder and output register
// ----------------------------------------------------------------------------
`default_nettype none

module clpm_dp import clpm_pkg::*; #(
	parameter int MAX_TERMS = 32,
	parameter int COEF_BITS = 18,
	localparam int IDX_W = $clog2(MAX_TERMS),
	localparam int K_W   = $clog2(2 * MAX_TERMS - 1),
	localparam int IN_W  = ((2 * COEF_BITS + START_W + 7) / 8) * 8
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic [IN_W-1:0]       in_data,
	input  wire cmd_t                  cmd,
	input  wire logic [IDX_W-1:0]      wr_addr,
	input  wire logic [IDX_W-1:0]      rd_addr_a,
	input  wire logic [IDX_W-1:0]      rd_addr_b,
	input  wire logic [K_W-1:0]        k_idx,
	output logic                       pipe_busy,
	output logic [OUT_DATA_W-1:0]      out_data,
	output logic                       out_last,
	output logic                       out_empty
);

	localparam int CW = 2 * COEF_BITS;

	logic        [CW-1:0]        wdata;
	logic signed [START_W-1:0]   start_in;
	logic        [CW-1:0]        a_rd;
	logic        [CW-1:0]        b_rd;
	logic signed [COEF_BITS-1:0] a_re, a_im, b_re, b_im;
	logic signed [CW-1:0]        mul_ac, mul_bd, mul_ad, mul_bc;

	logic                        valid_s1, valid_s2, valid_s3;
	logic signed [PROD_W-1:0]    ac_s2, bd_s2, ad_s2, bc_s2;
	logic signed [PROD_W-1:0]    term_re_s3, term_im_s3;
	logic signed [PROD_W-1:0]    acc_re_q, acc_im_q;
	logic signed [START_W-1:0]   start_a_q, start_b_q;
	logic        [EXP_W-1:0]     exp_sum;

	logic        [PROD_W-1:0]    prod_re_q, prod_im_q;
	logic        [EXP_W-1:0]     exp_q;
	logic                        last_q, empty_q;

	assign wdata    = in_data[CW-1:0];
	assign start_in = in_data[CW+START_W-1:CW];

	clpm_ram #(
		.WIDTH (CW),
		.DEPTH (MAX_TERMS)
	) u_store_a (
		.clk   (clk),
		.we    (cmd.wr_a),
		.waddr (wr_addr),
		.wdata (wdata),
		.raddr (rd_addr_a),
		.rdata (a_rd)
	);

	clpm_ram #(
		.WIDTH (CW),
		.DEPTH (MAX_TERMS)
	) u_store_b (
		.clk   (clk),
		.we    (cmd.wr_b),
		.waddr (wr_addr),
		.wdata (wdata),
		.raddr (rd_addr_b),
		.rdata (b_rd)
	);

	assign a_re = a_rd[COEF_BITS-1:0];
	assign a_im = a_rd[CW-1:COEF_BITS];
	assign b_re = b_rd[COEF_BITS-1:0];
	assign b_im = b_rd[CW-1:COEF_BITS];

	assign mul_ac = a_re * b_re;
	assign mul_bd = a_im * b_im;
	assign mul_ad = a_re * b_im;
	assign mul_bc = a_im * b_re;

	assign exp_sum = EXP_W'(start_a_q) + EXP_W'(start_b_q) + EXP_W'(k_idx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= cmd.issue;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_start_a) begin
			start_a_q <= start_in;
		end
		if (cmd.ld_start_b) begin
			start_b_q <= start_in;
		end
		// products, sign-extended or wrapped into the sum width
		ac_s2      <= PROD_W'(mul_ac);
		bd_s2      <= PROD_W'(mul_bd);
		ad_s2      <= PROD_W'(mul_ad);
		bc_s2      <= PROD_W'(mul_bc);
		term_re_s3 <= ac_s2 - bd_s2;
		term_im_s3 <= ad_s2 + bc_s2;
		if (cmd.acc_clr) begin
			acc_re_q <= '0;
			acc_im_q <= '0;
		end else if (valid_s3) begin
			acc_re_q <= acc_re_q + term_re_s3;
			acc_im_q <= acc_im_q + term_im_s3;
		end
		if (cmd.load_out) begin
			last_q <= cmd.out_last;
			if (cmd.out_empty) begin
				prod_re_q <= '0;
				prod_im_q <= '0;
				exp_q     <= '0;
				empty_q   <= 1'b1;
			end else begin
				prod_re_q <= acc_re_q;
				prod_im_q <= acc_im_q;
				exp_q     <= exp_sum;
				empty_q   <= 1'b0;
			end
		end
	end

	assign pipe_busy = valid_s1 | valid_s2 | valid_s3;
	assign out_data  = {{OUT_PAD_W{1'b0}}, exp_q, prod_im_q, prod_re_q};
	assign out_last  = last_q;
	assign out_empty = empty_q;

endmodule

`default_nettype wire

// File: hdl/clpm_ctrl.sv
// ----------------------------------------------------------------------------
// clpm_ctrl
// controller: operand loading, term counts and the convolution sequencer
// that walks output index k and inner index i
// ----------------------------------------------------------------------------
`default_nettype none

module clpm_ctrl import clpm_pkg::*; #(
	parameter int MAX_TERMS = 32,
	localparam int IDX_W = $clog2(MAX_TERMS),
	localparam int CNT_W = $clog2(MAX_TERMS + 1),
	localparam int K_W   = $clog2(2 * MAX_TERMS - 1)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic             in_last,
	input  wire logic [1:0]       in_user,
	output logic                  out_valid,
	input  wire logic             out_ready,
	input  wire logic             pipe_busy,
	output cmd_t                  cmd,
	output logic [IDX_W-1:0]      wr_addr,
	output logic [IDX_W-1:0]      rd_addr_a,
	output logic [IDX_W-1:0]      rd_addr_b,
	output logic [K_W-1:0]        k_idx
);

	localparam int SW = K_W + 1;

	typedef enum logic [4:0] {
		ST_LOAD  = 5'b00001,
		ST_EMPTY = 5'b00010,
		ST_SETUP = 5'b00100,
		ST_ISSUE = 5'b01000,
		ST_DRAIN = 5'b10000
	} state_t;

	state_t           state_q, state_d;
	logic [CNT_W-1:0] first_count_q, second_count_q;
	logic             empty_seen_q, first_done_q, second_started_q;
	logic [K_W-1:0]   k_q;
	logic [IDX_W-1:0] i_q, i_hi_q;
	logic             out_valid_q;

	logic             accept, req, emp, out_free;
	logic [CNT_W-1:0] eff_cnt;
	logic             a_room, b_room, empty_prod;
	logic [SW-1:0]    k_ext, na_ext, nb_ext, kmax;
	logic             k_is_last;
	logic [IDX_W-1:0] i_lo, i_hi;

	assign in_ready   = (state_q == ST_LOAD);
	assign accept     = in_valid & in_ready;
	assign req        = in_user[TUSER_REQ_BIT];
	assign emp        = in_user[TUSER_EMPTY_BIT];
	assign out_free   = !out_valid_q || out_ready;
	assign eff_cnt    = first_done_q ? '0 : first_count_q;
	assign a_room     = eff_cnt < CNT_W'(MAX_TERMS);
	assign b_room     = second_count_q < CNT_W'(MAX_TERMS);
	assign empty_prod = emp || empty_seen_q || (first_count_q == '0);

	assign k_ext     = SW'(k_q);
	assign na_ext    = SW'(first_count_q);
	assign nb_ext    = SW'(second_count_q);
	assign kmax      = na_ext + nb_ext - SW'(2);
	assign k_is_last = (k_ext == kmax);

	// valid range of i for the current k
	assign i_lo = (k_ext >= nb_ext) ? IDX_W'(k_ext - nb_ext + SW'(1)) : '0;
	assign i_hi = (k_ext < na_ext) ? IDX_W'(k_q) : IDX_W'(first_count_q - CNT_W'(1));

	assign wr_addr   = (req == REQ_SECOND) ? IDX_W'(second_count_q) : IDX_W'(eff_cnt);
	assign rd_addr_a = i_q;
	assign rd_addr_b = IDX_W'(k_q - K_W'(i_q));
	assign k_idx     = k_q;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_LOAD: begin
				if (accept) begin
					if (req == REQ_FIRST) begin
						if (!emp) begin
							cmd.ld_start_a = (eff_cnt == '0);
							cmd.wr_a       = a_room;
						end
					end else begin
						if (!emp) begin
							cmd.ld_start_b = !second_started_q;
							cmd.wr_b       = b_room;
						end
						if (emp || in_last) begin
							state_d = empty_prod ? ST_EMPTY : ST_SETUP;
						end
					end
				end
			end
			ST_EMPTY: begin
				if (out_free) begin
					cmd.load_out  = 1'b1;
					cmd.out_empty = 1'b1;
					cmd.out_last  = 1'b1;
					state_d       = ST_LOAD;
				end
			end
			ST_SETUP: begin
				cmd.acc_clr = 1'b1;
				state_d     = ST_ISSUE;
			end
			ST_ISSUE: begin
				cmd.issue = 1'b1;
				if (i_q == i_hi_q) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!pipe_busy && out_free) begin
					cmd.load_out = 1'b1;
					cmd.out_last = k_is_last;
					state_d      = k_is_last ? ST_LOAD : ST_SETUP;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_LOAD;
			first_count_q    <= '0;
			second_count_q   <= '0;
			empty_seen_q     <= 1'b0;
			first_done_q     <= 1'b0;
			second_started_q <= 1'b0;
			k_q              <= '0;
			i_q              <= '0;
			i_hi_q           <= '0;
			out_valid_q      <= 1'b0;
		end else begin
			state_q <= state_d;

			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			if (accept) begin
				if (req == REQ_FIRST) begin
					if (emp) begin
						first_count_q <= '0;
						empty_seen_q  <= 1'b1;
						first_done_q  <= 1'b1;
					end else begin
						first_count_q <= a_room ? eff_cnt + CNT_W'(1) : eff_cnt;
						empty_seen_q  <= 1'b0;
						first_done_q  <= in_last;
					end
				end else begin
					if (!emp) begin
						second_started_q <= 1'b1;
						if (b_room) begin
							second_count_q <= second_count_q + CNT_W'(1);
						end
					end
					if (emp || in_last) begin
						k_q <= '0;
						if (empty_prod) begin
							first_count_q    <= '0;
							second_count_q   <= '0;
							empty_seen_q     <= 1'b0;
							first_done_q     <= 1'b0;
							second_started_q <= 1'b0;
						end
					end
				end
			end

			if (state_q == ST_SETUP) begin
				i_q    <= i_lo;
				i_hi_q <= i_hi;
			end

			if (state_q == ST_ISSUE && i_q != i_hi_q) begin
				i_q <= i_q + IDX_W'(1);
			end

			if (state_q == ST_DRAIN && cmd.load_out) begin
				if (k_is_last) begin
					first_count_q    <= '0;
					second_count_q   <= '0;
					empty_seen_q     <= 1'b0;
					first_done_q     <= 1'b0;
					second_started_q <= 1'b0;
				end else begin
					k_q <= k_q + K_W'(1);
				end
			end
		end
	end

`ifndef SYNTH
	a_load_idle_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_LOAD |-> !pipe_busy)
		else $error("input taken while mac pipeline busy");

	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || out_ready))
		else $error("output register overwritten");

	a_i_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ISSUE |-> i_q <= i_hi_q)
		else $error("inner index past its bound");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		first_count_q <= CNT_W'(MAX_TERMS) && second_count_q <= CNT_W'(MAX_TERMS))
		else $error("term count beyond store depth");

	a_issue_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |=> pipe_busy)
		else $error("issued term lost from pipeline");
`endif

endmodule

`default_nettype wire

// File: hdl/complex_laurent_poly_multiply.sv
// ----------------------------------------------------------------------------
// complex_laurent_poly_multiply
// product of two laurent polynomials with complex q1.16 coefficients
// ----------------------------------------------------------------------------
// Load operand A beats (tuser req_type 0) then operand B beats (req_type 1),
// one coefficient per beat, lowest exponent first, start exponent read on the
// first beat of each operand and tlast on its final beat. Loading takes one
// beat per cycle. After B's final beat the block streams the na+nb-1
// coefficients of the product in ascending exponent order, exact q9.32, with
// tlast on the final one; an empty operand gives a single beat flagged in
// tuser. No input is taken while a product is being computed. One shared
// complex multiply-accumulate unit (four multipliers, three pipeline stages)
// takes one term per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module complex_laurent_poly_multiply import clpm_pkg::*; #(
	parameter int MAX_TERMS = 32,
	parameter int COEF_BITS = 18,
	localparam int IN_W  = ((2 * COEF_BITS + START_W + 7) / 8) * 8
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,

	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	// coef_re, coef_im, start_exponent, zero pad
	input  wire logic [IN_W-1:0]       s_axis_tdata,
	// last_term
	input  wire logic                  s_axis_tlast,
	// req_type, operand_empty
	input  wire logic [1:0]            s_axis_tuser,

	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	// prod_re, prod_im, exponent, zero pad
	output logic [OUT_DATA_W-1:0]      m_axis_tdata,
	// last_out
	output logic                       m_axis_tlast,
	// result_empty
	output logic                       m_axis_tuser
);

	localparam int IDX_W = $clog2(MAX_TERMS);
	localparam int K_W   = $clog2(2 * MAX_TERMS - 1);

	cmd_t             cmd;
	logic             pipe_busy;
	logic [IDX_W-1:0] wr_addr, rd_addr_a, rd_addr_b;
	logic [K_W-1:0]   k_idx;

	clpm_ctrl #(
		.MAX_TERMS (MAX_TERMS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_last   (s_axis_tlast),
		.in_user   (s_axis_tuser),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.pipe_busy (pipe_busy),
		.cmd       (cmd),
		.wr_addr   (wr_addr),
		.rd_addr_a (rd_addr_a),
		.rd_addr_b (rd_addr_b),
		.k_idx     (k_idx)
	);

	clpm_dp #(
		.MAX_TERMS (MAX_TERMS),
		.COEF_BITS (COEF_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (s_axis_tdata),
		.cmd       (cmd),
		.wr_addr   (wr_addr),
		.rd_addr_a (rd_addr_a),
		.rd_addr_b (rd_addr_b),
		.k_idx     (k_idx),
		.pipe_busy (pipe_busy),
		.out_data  (m_axis_tdata),
		.out_last  (m_axis_tlast),
		.out_empty (m_axis_tuser)
	);

endmodule

`default_nettype wire
